// ----- src/catan_pkg.sv -----
// Shared widths, constants and the arctangent table for the CORDIC angle block.
package catan_pkg;

    // Input and output field widths
    localparam int unsigned IN_W    = 16;
    localparam int unsigned ANGLE_W = 15;

    // Datapath widths: x/y grow by the CORDIC gain after the sign fold
    localparam int unsigned XY_W  = 19;
    // Angle accumulator in Q16 turns, covers +/- half turn plus table sum
    localparam int unsigned ACC_W = 18;
    localparam int unsigned TAB_W = 14;

    // Half a turn in Q16 turns
    localparam logic signed [ACC_W-1:0] HALF_TURN_Q16 = ACC_W'(32768);

    // Arctangent of 2^-i in Q16 turns
    function automatic logic [TAB_W-1:0] atan_q16(input logic [3:0] idx);
        logic [TAB_W-1:0] v;
        unique case (idx)
            4'd0:    v = 14'd8192;
            4'd1:    v = 14'd4836;
            4'd2:    v = 14'd2555;
            4'd3:    v = 14'd1297;
            4'd4:    v = 14'd651;
            4'd5:    v = 14'd326;
            4'd6:    v = 14'd163;
            4'd7:    v = 14'd81;
            4'd8:    v = 14'd41;
            4'd9:    v = 14'd20;
            4'd10:   v = 14'd10;
            4'd11:   v = 14'd5;
            4'd12:   v = 14'd3;
            4'd13:   v = 14'd1;
            4'd14:   v = 14'd1;
            4'd15:   v = 14'd0;
            default: v = 14'd0;
        endcase
        return v;
    endfunction

endpackage

// ----- src/cordic_atan2_turns.sv -----
// Vectoring CORDIC: angle of a signed Q15 (y, x) pair as a Q15 fraction of a turn.
//
// Input channel: i_valid / o_ready carry one word (i_y_value, i_x_value).
// Output channel: o_valid / i_ready carry one word (o_angle_turns), where
// 32768 would be a full turn; a zero vector gives zero.
// A word goes from the input register through the middle register to the
// result register, which drives o_valid. Throughput: one word per cycle
// unless stalled. The registers split the work; the first half of micro-rotations
// (with the left half plane fold) sits before the middle register and the
// rest (with the final halving) before the result register, so the longest
// path is about ROTATIONS/2 dependent 19-bit add/subtract steps.
// Stall: when the receiver holds i_ready low the result stays put, and the
// earlier stages keep filling; o_ready drops only once all three are full.
// Reset: i_rst_n (synchronous, active low) empties all three stages; no
// result is pending afterward.
module cordic_atan2_turns
    import catan_pkg::*;
#(
    parameter int unsigned ROTATIONS = 14
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic signed [IN_W-1:0]    i_y_value,
    input  logic signed [IN_W-1:0]    i_x_value,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic        [ANGLE_W-1:0] o_angle_turns
);

    localparam int unsigned FIRST = ROTATIONS / 2;

    // Stage valids and payloads
    logic                     r_v1, r_v2, r_v3;
    logic signed [IN_W-1:0]   r_y, r_x;
    logic signed [XY_W-1:0]   r_mx, r_my;
    logic signed [ACC_W-1:0]  r_macc;
    logic                     r_mzero;
    logic        [ANGLE_W-1:0] r_angle;

    logic s1_free, s2_free, s3_free;
    logic signed [XY_W-1:0]   n_mx, n_my;
    logic signed [ACC_W-1:0]  n_macc;
    logic                     n_mzero;
    logic        [ANGLE_W-1:0] n_angle;

    // Stage can take a word when empty or its word moves on
    assign s3_free = !r_v3 || i_ready;
    assign s2_free = !r_v2 || s3_free;
    assign s1_free = !r_v1 || s2_free;
    assign o_ready = s1_free;

    // First pass: fold into right half plane, then first micro-rotations
    always_comb begin : first_pass
        logic signed [XY_W-1:0]  xc, yc, nx, ny;
        logic signed [ACC_W-1:0] acc;
        xc  = XY_W'(r_x);
        yc  = XY_W'(r_y);
        acc = '0;
        if (r_x[IN_W-1]) begin
            acc = r_y[IN_W-1] ? -HALF_TURN_Q16 : HALF_TURN_Q16;
            xc  = -xc;
            yc  = -yc;
        end
        for (int i = 0; i < int'(FIRST); i++) begin
            if (!yc[XY_W-1] && (yc != '0)) begin
                nx  = xc + (yc >>> i);
                ny  = yc - (xc >>> i);
                acc = acc + $signed({{(ACC_W-TAB_W){1'b0}}, atan_q16(4'(i))});
            end else begin
                nx  = xc - (yc >>> i);
                ny  = yc + (xc >>> i);
                acc = acc - $signed({{(ACC_W-TAB_W){1'b0}}, atan_q16(4'(i))});
            end
            xc = nx;
            yc = ny;
        end
        n_mx    = xc;
        n_my    = yc;
        n_macc  = acc;
        n_mzero = (r_x == '0) && (r_y == '0);
    end

    // Second pass: remaining micro-rotations, halve toward zero, wrap
    always_comb begin : second_pass
        logic signed [XY_W-1:0]  xc, yc, nx, ny;
        logic signed [ACC_W-1:0] acc, half;
        xc  = r_mx;
        yc  = r_my;
        acc = r_macc;
        for (int i = int'(FIRST); i < int'(ROTATIONS); i++) begin
            if (!yc[XY_W-1] && (yc != '0)) begin
                nx  = xc + (yc >>> i);
                ny  = yc - (xc >>> i);
                acc = acc + $signed({{(ACC_W-TAB_W){1'b0}}, atan_q16(4'(i))});
            end else begin
                nx  = xc - (yc >>> i);
                ny  = yc + (xc >>> i);
                acc = acc - $signed({{(ACC_W-TAB_W){1'b0}}, atan_q16(4'(i))});
            end
            xc = nx;
            yc = ny;
        end
        // Truncating divide by two: bias negatives by one before the shift
        half    = (acc + $signed({{(ACC_W-1){1'b0}}, acc[ACC_W-1]})) >>> 1;
        n_angle = r_mzero ? '0 : half[ANGLE_W-1:0];
    end

    // Stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (s1_free) r_v1 <= i_valid;
            if (s2_free) r_v2 <= r_v1;
            if (s3_free) r_v3 <= r_v2;
        end
    end

    // Stage payloads
    always_ff @(posedge i_clk) begin
        if (s1_free && i_valid) begin
            r_y <= i_y_value;
            r_x <= i_x_value;
        end
        if (s2_free && r_v1) begin
            r_mx    <= n_mx;
            r_my    <= n_my;
            r_macc  <= n_macc;
            r_mzero <= n_mzero;
        end
        if (s3_free && r_v2) begin
            r_angle <= n_angle;
        end
    end

    assign o_valid       = r_v3;
    assign o_angle_turns = r_angle;

`ifndef ASSERT_OFF
    // A zero vector in the input register carries its flag into the middle stage
    a_zero_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && s2_free && (r_x == '0) && (r_y == '0)) |=> r_mzero)
        else $error("zero vector flag lost between stages");

    // A middle word is never dropped while the result stage is blocked
    a_mid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && !s3_free) |=> r_v2)
        else $error("middle stage word lost during stall");

    // Input side is held off only when every stage is full and stalled
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (r_v1 && r_v2 && r_v3 && !i_ready))
        else $error("input held off with room in the pipeline");
`endif

endmodule

// ----- sim/cordic_atan2_turns_tb.sv -----
// Self-checking testbench for the vectoring CORDIC angle block cordic_atan2_turns.
`timescale 1ns / 1ps

module cordic_atan2_turns_tb
    import catan_pkg::*;
();

    localparam int ROTATIONS   = 14;
    localparam int HALF_Q16    = 32768;
    localparam int TURN_Q15    = 32768;
    localparam int DIR_N       = 21;
    localparam int RAND_N      = 1400;
    localparam int DRAIN_CYC   = 12;
    localparam int IDLE_LIMIT  = 2000;
    localparam int PRESS_CYC   = 120;

    // Arctangent of 2^-i in Q16 turns
    localparam int ATAN_Q16 [16] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81,
                                     41, 20, 10, 5, 3, 1, 1, 0};

    typedef struct packed {
        logic signed [IN_W-1:0]  y;
        logic signed [IN_W-1:0]  x;
        logic                    known;
        logic [ANGLE_W-1:0]      angle;
    } t_vector;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_valid = 1'b0;
    logic                      o_ready;
    logic signed [IN_W-1:0]    i_y_value = '0;
    logic signed [IN_W-1:0]    i_x_value = '0;
    logic                      o_valid;
    logic                      i_ready = 1'b0;
    logic        [ANGLE_W-1:0] o_angle_turns;

    t_vector            directed_rows [DIR_N];
    t_vector            vectors_q [$];
    logic [ANGLE_W-1:0] pending_angles [$];
    int                 accepted_words = 0;
    int                 errors = 0;

    cordic_atan2_turns #(.ROTATIONS(ROTATIONS)) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_y_value     (i_y_value),
        .i_x_value     (i_x_value),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_angle_turns (o_angle_turns)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Angle of (y, x) in Q15 turns: sign fold, micro-rotations, halve and wrap
    function automatic logic [ANGLE_W-1:0] turn_fraction(input logic signed [IN_W-1:0] y_in,
                                                          input logic signed [IN_W-1:0] x_in);
        int y;
        int x;
        int nx;
        int ny;
        int acc;
        int half;
        int k;
        y   = y_in;
        x   = x_in;
        acc = 0;
        if (x == 0 && y == 0)
            return '0;
        if (x < 0) begin
            acc = (y >= 0) ? HALF_Q16 : -HALF_Q16;
            x   = -x;
            y   = -y;
        end
        for (k = 0; k < ROTATIONS; k++) begin
            // zero y steers the same way as negative y
            if (y > 0) begin
                nx  = x + (y >>> k);
                ny  = y - (x >>> k);
                acc = acc + ATAN_Q16[k % 16];
            end else begin
                nx  = x - (y >>> k);
                ny  = y + (x >>> k);
                acc = acc - ATAN_Q16[k % 16];
            end
            x = nx;
            y = ny;
        end
        half = acc / 2;
        half = half % TURN_Q15;
        if (half < 0)
            half = half + TURN_Q15;
        return half[ANGLE_W-1:0];
    endfunction

    // One random vector, mixing full range with corners, axes and diagonals
    function automatic t_vector random_vector();
        t_vector v;
        logic signed [IN_W-1:0] corners [7];
        int mode;
        corners = '{16'sh8000, 16'sh8001, -16'sd1, 16'sd0, 16'sd1, 16'sh7ffe, 16'sh7fff};
        v.known = 1'b0;
        v.angle = '0;
        mode = $urandom_range(0, 9);
        unique case (mode)
            5: begin
                v.y = IN_W'($signed($urandom_range(0, 16)) - 8);
                v.x = IN_W'($signed($urandom_range(0, 16)) - 8);
            end
            6: begin
                v.y = IN_W'($urandom());
                v.x = '0;
                if ($urandom_range(0, 1)) begin
                    v.x = v.y;
                    v.y = '0;
                end
            end
            7: begin
                v.y = corners[$urandom_range(0, 6)];
                v.x = corners[$urandom_range(0, 6)];
            end
            8: begin
                v.y = IN_W'($urandom());
                v.x = $urandom_range(0, 1) ? v.y : -v.y;
            end
            9: begin
                v.y = IN_W'($signed($urandom_range(0, 6)) - 3);
                v.x = IN_W'($urandom());
                if ($urandom_range(0, 1)) begin
                    v.y = v.x;
                    v.x = IN_W'($signed($urandom_range(0, 6)) - 3);
                end
            end
            default: begin
                v.y = IN_W'($urandom());
                v.x = IN_W'($urandom());
            end
        endcase
        return v;
    endfunction

    // Sender gap: mostly none or short, now and then long
    function automatic int send_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Stimulus: reset, directed table, random vectors, then drain
    initial begin : stimulus
        t_vector v;
        int      k;
        int      gap;
        int      burst_left;
        burst_left = 0;

        // y, x, typed expectation flag, typed angle
        directed_rows = '{
            '{16'sd0,     16'sd0,     1'b1, 15'd0},   // zero vector
            '{16'sd0,     16'sh7fff,  1'b0, 15'd0},
            '{16'sd0,     16'sh8000,  1'b0, 15'd0},   // negative x, y zero
            '{16'sh7fff,  16'sd0,     1'b0, 15'd0},
            '{16'sh8000,  16'sd0,     1'b0, 15'd0},
            '{16'sh7fff,  16'sh7fff,  1'b0, 15'd0},
            '{16'sh8000,  16'sh8000,  1'b0, 15'd0},
            '{16'sh7fff,  16'sh8000,  1'b0, 15'd0},
            '{16'sh8000,  16'sh7fff,  1'b0, 15'd0},
            '{16'sd1,     16'sd0,     1'b0, 15'd0},
            '{-16'sd1,    16'sd0,     1'b0, 15'd0},
            '{16'sd0,     16'sd1,     1'b0, 15'd0},
            '{16'sd0,     -16'sd1,    1'b0, 15'd0},
            '{16'sd1,     16'sd1,     1'b0, 15'd0},
            '{-16'sd1,    -16'sd1,    1'b0, 15'd0},
            '{16'sd1,     -16'sd1,    1'b0, 15'd0},
            '{-16'sd1,    16'sd1,     1'b0, 15'd0},
            '{16'sd100,   -16'sd5,    1'b0, 15'd0},   // left half, upper start
            '{-16'sd100,  -16'sd5,    1'b0, 15'd0},   // left half, lower start
            '{16'sd0,     -16'sd5,    1'b0, 15'd0},
            '{16'sd5,     -16'sd100,  1'b0, 15'd0}
        };
        for (k = 0; k < DIR_N; k++)
            vectors_q.push_back(directed_rows[k]);
        for (k = 0; k < RAND_N; k++)
            vectors_q.push_back(random_vector());

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (k = 0; k < vectors_q.size(); k++) begin
            v = vectors_q[k];
            i_valid   <= 1'b1;
            i_y_value <= v.y;
            i_x_value <= v.x;
            @(posedge i_clk);
            while (!o_ready)
                @(posedge i_clk);
            // word taken at this edge
            pending_angles.push_back(v.known ? v.angle : turn_fraction(v.y, v.x));
            accepted_words++;

            if (burst_left > 0) begin
                burst_left--;
                gap = 0;
            end else begin
                gap = send_gap();
                if ($urandom_range(0, 49) == 0)
                    burst_left = $urandom_range(30, 100);
            end
            if (gap > 0 || k == vectors_q.size() - 1) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end

        while (pending_angles.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);

        if (errors == 0 && pending_angles.size() == 0) begin
            $display("cordic_atan2_turns_tb passed");
        end else begin
            $display("cordic_atan2_turns_tb failed");
        end
        $finish;
    end

    // Receiver: random ready pattern, two long hold-offs, result check
    initial begin : receiver
        logic [ANGLE_W-1:0] want;
        int  hold;
        int  stall_left;
        int  presses;
        bit  ready_level;
        hold        = 0;
        stall_left  = 0;
        presses     = 0;
        ready_level = 1'b1;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            @(posedge i_clk);
            if (o_valid && i_ready) begin
                if (pending_angles.size() == 0) begin
                    $display("%0t: angle %0d with nothing expected", $time, o_angle_turns);
                    errors++;
                end else begin
                    want = pending_angles.pop_front();
                    if (o_angle_turns !== want) begin
                        $display("%0t: angle expected %0d got %0d",
                                 $time, want, o_angle_turns);
                        errors++;
                    end
                end
            end

            // long hold-off so the pipe fills and stalls the sender
            if ((presses == 0 && accepted_words >= 400) ||
                (presses == 1 && accepted_words >= 1000)) begin
                stall_left = PRESS_CYC;
                presses++;
            end

            if (stall_left > 0) begin
                stall_left--;
                i_ready <= 1'b0;
            end else begin
                if (hold == 0) begin
                    ready_level = ($urandom_range(0, 3) != 0);
                    if (ready_level)
                        hold = $urandom_range(1, ($urandom_range(0, 9) == 0) ? 150 : 12);
                    else if ($urandom_range(0, 9) == 0)
                        hold = $urandom_range(8, 40);
                    else
                        hold = $urandom_range(1, 3);
                end
                hold--;
                i_ready <= ready_level;
            end
        end
    end

    // Watchdog: too many cycles with no word moving on either side
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
        $display("cordic_atan2_turns_tb failed");
        $finish;
    end

endmodule

// ----- cordic_atan2_turns.f -----
src/catan_pkg.sv
src/cordic_atan2_turns.sv
sim/cordic_atan2_turns_tb.sv
